### sv/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types and constants for the PACE response deframer.
// ----------------------------------------------------------------------------
package prd_pkg;

  localparam logic [31:0] SUCCESS_CODE = 32'h0000_0000;
  localparam logic [16:0] COUNT_MAX    = 17'h1_FFFF;
  localparam logic [16:0] HDR_BYTES    = 17'd6;

  typedef enum logic [3:0] {
    PH_NONE      = 4'd0,
    PH_RESULT    = 4'd1,
    PH_OUTER     = 4'd2,
    PH_MSE       = 4'd3,
    PH_ACC_LEN   = 4'd4,
    PH_ACC_DATA  = 4'd5,
    PH_CAR_LEN   = 4'd6,
    PH_CAR_DATA  = 4'd7,
    PH_PREV_LEN  = 4'd8,
    PH_PREV_DATA = 4'd9,
    PH_ID_LEN    = 4'd10,
    PH_ID_DATA   = 4'd11,
    PH_DONE      = 4'd12,
    PH_TRAIL     = 4'd13,
    PH_IGNORE    = 4'd14
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TRUNC    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_TRAILING = 3'd3,
    ST_READER   = 3'd4
  } status_t;

  typedef struct packed {
    logic [3:0]  segment;
    logic [7:0]  byte_out;
    logic        payload_valid;
    logic        field_end;
    logic        done_res;
    logic [2:0]  status;
    logic [31:0] reader_code;
    logic [15:0] mse_status;
  } res_t;

endpackage

### sv/pace_response_deframer_unit.sv
// ----------------------------------------------------------------------------
// pace_response_deframer_unit
// Byte-wise parser for the Establish PACE Channel response frame.
// ----------------------------------------------------------------------------
// Each result beat is registered: in the output register, or in the skid while the output is held.
// Throughput: one byte per cycle while in_stall is low; the parse state updates in the accept cycle.
// A two-deep result stage (output register plus skid) keeps input flowing
// while a result waits; in_stall rises only when both are full.
// Reset: synchronous, parser back to result-code phase, result stage empty.
// The parser also returns to its reset state after each final byte.
module pace_response_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  segment,
  output logic [7:0]  byte_out,
  output logic        payload_valid,
  output logic        field_end,
  output logic        done_res,
  output logic [2:0]  status,
  output logic [31:0] reader_code,
  output logic [15:0] mse_status
);
  import prd_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] field_count, field_count_next;
  logic [15:0] field_length, field_length_next;
  logic [16:0] total_count, total_count_next;
  logic [15:0] outer_length, outer_length_next;
  logic [31:0] code_reg, code_reg_next;
  logic [15:0] mse_reg, mse_reg_next;
  status_t     error_code, error_code_next;

  res_t        res, out_res, skid_res;
  logic        skid_valid;
  logic        accept, out_take;
  logic [16:0] k_inc;
  logic [16:0] frame_len_next;
  logic [16:0] frame_len_cur;
  status_t     st;

  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = skid_valid;

  assign frame_len_cur  = HDR_BYTES + {1'b0, outer_length};
  assign frame_len_next = HDR_BYTES + {1'b0, outer_length_next};

  always_comb begin
    phase_next        = phase;
    field_count_next  = field_count;
    field_length_next = field_length;
    outer_length_next = outer_length;
    code_reg_next     = code_reg;
    mse_reg_next      = mse_reg;
    error_code_next   = error_code;
    total_count_next  = (total_count != COUNT_MAX) ? total_count + 17'd1 : total_count;
    res               = '0;
    res.byte_out      = data_byte;
    res.done_res      = final_byte;
    k_inc             = {1'b0, field_count} + 17'd1;

    if (error_code == ST_OK && phase >= PH_MSE && phase <= PH_TRAIL &&
        total_count_next > frame_len_cur) begin
      error_code_next = ST_MISMATCH;
      phase_next      = PH_IGNORE;
    end

    case (phase_next)
      PH_RESULT: begin
        res.segment = 4'(PH_RESULT);
        case (field_count[1:0])
          2'd0:    code_reg_next[7:0]   = code_reg[7:0]   | data_byte;
          2'd1:    code_reg_next[15:8]  = code_reg[15:8]  | data_byte;
          2'd2:    code_reg_next[23:16] = code_reg[23:16] | data_byte;
          default: code_reg_next[31:24] = code_reg[31:24] | data_byte;
        endcase
        field_count_next = k_inc[15:0];
        if (k_inc >= 17'd4) begin
          field_count_next = '0;
          if (code_reg_next != SUCCESS_CODE) begin
            error_code_next = ST_READER;
            phase_next      = PH_IGNORE;
          end else begin
            phase_next = PH_OUTER;
          end
        end
      end
      PH_OUTER, PH_MSE: begin
        res.segment = 4'(phase_next);
        if (phase_next == PH_OUTER) begin
          outer_length_next = (field_count == '0) ? {8'd0, data_byte}
                                                  : (outer_length | {data_byte, 8'd0});
        end else begin
          mse_reg_next = (field_count == '0) ? {8'd0, data_byte}
                                             : (mse_reg | {data_byte, 8'd0});
        end
        field_count_next = k_inc[15:0];
        if (k_inc >= 17'd2) begin
          field_count_next = '0;
          phase_next       = phase_t'(phase_next + 4'd1);
        end
      end
      PH_ACC_LEN, PH_ID_LEN: begin
        res.segment       = 4'(phase_next);
        field_length_next = (field_count == '0) ? {8'd0, data_byte}
                                                : (field_length | {data_byte, 8'd0});
        field_count_next  = k_inc[15:0];
        if (k_inc >= 17'd2) begin
          field_count_next = '0;
          phase_next = (field_length_next == '0) ? phase_t'(phase_next + 4'd2)
                                                 : phase_t'(phase_next + 4'd1);
        end
      end
      PH_CAR_LEN, PH_PREV_LEN: begin
        res.segment       = 4'(phase_next);
        field_length_next = {8'd0, data_byte};
        field_count_next  = '0;
        phase_next = (data_byte == 8'd0) ? phase_t'(phase_next + 4'd2)
                                         : phase_t'(phase_next + 4'd1);
      end
      PH_ACC_DATA, PH_CAR_DATA, PH_PREV_DATA, PH_ID_DATA: begin
        res.segment       = 4'(phase_next);
        res.payload_valid = 1'b1;
        field_count_next  = k_inc[15:0];
        if (k_inc >= {1'b0, field_length}) begin
          res.field_end     = 1'b1;
          field_count_next  = '0;
          field_length_next = '0;
          phase_next        = phase_t'(phase_next + 4'd1);
        end
      end
      PH_DONE, PH_TRAIL: phase_next = PH_TRAIL;
      default:           phase_next = PH_IGNORE;
    endcase

    if (final_byte) begin
      if (error_code_next == ST_READER)            st = ST_READER;
      else if (total_count_next < HDR_BYTES)       st = ST_TRUNC;
      else if (total_count_next != frame_len_next) st = ST_MISMATCH;
      else if (phase_next < PH_DONE)               st = ST_TRUNC;
      else if (phase_next == PH_TRAIL)             st = ST_TRAILING;
      else                                         st = ST_OK;
    end else begin
      st = error_code_next;
    end

    res.status      = 3'(st);
    res.reader_code = code_reg_next;
    res.mse_status  = mse_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && final_byte)) begin
      phase        <= PH_RESULT;
      field_count  <= '0;
      field_length <= '0;
      total_count  <= '0;
      outer_length <= '0;
      code_reg     <= '0;
      mse_reg      <= '0;
      error_code   <= ST_OK;
    end else if (accept) begin
      phase        <= phase_next;
      field_count  <= field_count_next;
      field_length <= field_length_next;
      total_count  <= total_count_next;
      outer_length <= outer_length_next;
      code_reg     <= code_reg_next;
      mse_reg      <= mse_reg_next;
      error_code   <= error_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= res;
      end
    end else if (accept) begin
      skid_res <= res;
    end
  end

  assign segment       = out_res.segment;
  assign byte_out      = out_res.byte_out;
  assign payload_valid = out_res.payload_valid;
  assign field_end     = out_res.field_end;
  assign done_res      = out_res.done_res;
  assign status        = out_res.status;
  assign reader_code   = out_res.reader_code;
  assign mse_status    = out_res.mse_status;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output register is empty");

  a_final_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && final_byte) |=> (phase == PH_RESULT && total_count == '0))
    else $error("parser not back in result phase after final beat");

  a_end_in_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && field_end) |-> (payload_valid && segment[0]))
    else $error("field end outside a data segment");

  a_count_below_len: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ACC_DATA || phase == PH_CAR_DATA || phase == PH_PREV_DATA ||
     phase == PH_ID_DATA) |-> (field_count < field_length))
    else $error("data byte count ran past field length");

endmodule
